// ----- rtl/core/lmst_pkg.sv -----
`default_nettype none
package lmst_pkg;

   // Field and register widths.
   localparam int CFG_W   = 11;
   localparam int DIM_W   = 13;
   localparam int ACC_W   = 58;
   localparam int TOT_W   = 28;
   localparam int CEN_W   = 19;
   localparam int SIZE_W  = 12;
   localparam int SHIFT_W = 20;
   localparam int DENS_W  = 16;
   localparam int DIVD_W  = 58;
   localparam int DIVS_W  = 32;
   localparam int ROOT_W  = 14;
   localparam int BIT_W   = 4;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // Saturation limits and reset values.
   localparam logic [CEN_W-1:0]  SHIFT_MAX   = 19'd262144;
   localparam logic [DENS_W-1:0] DENS_MAX    = 16'hFFFF;
   localparam logic [CFG_W-1:0]  FW_RESET    = 11'd640;
   localparam logic [CFG_W-1:0]  FH_RESET    = 11'd480;
   localparam logic [CFG_W-1:0]  DSIZE_RESET = 11'd32;
   localparam logic [BIT_W-1:0]  ROOT_TOP    = 4'd13;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KERNEL_MODE  = 2'd2;
   localparam logic [1:0] REG_DEFAULT_SIZE = 2'd3;

   typedef enum logic [1:0] {
      SEL_X   = 2'd0,
      SEL_Y   = 2'd1,
      SEL_DEN = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
      logic             kernel_mode;
      logic [CFG_W-1:0] default_size;
   } cfg_type;

   typedef struct packed {
      logic             pix;
      logic             sq_init;
      logic             sq_mul;
      logic             sq_test;
      logic [BIT_W-1:0] bit_idx;
      logic             nsq;
      logic             n9;
      logic             div_start;
      logic             div_store;
      div_sel_type      sel;
      logic             fin;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic found;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/lmst_div.sv -----
`default_nettype none
module lmst_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lmst_pkg::DIVD_W-1:0] dividend,
   input  wire logic [lmst_pkg::DIVS_W-1:0] divisor,
   output logic                             done,
   output logic [lmst_pkg::DIVD_W-1:0]      quotient
);
   import lmst_pkg::*;

   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIVS_W:0]   rem_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic [DIVS_W-1:0] dvs_ff;
   logic [DIVS_W:0]   trial;
   logic              ge;

   // One quotient bit per cycle, restoring form.
   assign trial = {rem_ff[DIVS_W-1:0], quo_ff[DIVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DIVD_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   // Remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial - {1'b0, dvs_ff} : trial;
         quo_ff <= {quo_ff[DIVD_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/lmst_dp.sv -----
`default_nettype none
module lmst_dp #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lmst_pkg::cfg_type            cfg,
   input  wire lmst_pkg::cmd_type            cmd,
   output lmst_pkg::sts_type                 sts,
   input  wire logic [7:0]                   luminance,
   output logic signed [lmst_pkg::SHIFT_W-1:0] shift_x,
   output logic signed [lmst_pkg::SHIFT_W-1:0] shift_y,
   output logic [lmst_pkg::CEN_W-1:0]        center_x,
   output logic [lmst_pkg::CEN_W-1:0]        center_y,
   output logic [lmst_pkg::SIZE_W-1:0]       window_size,
   output logic [lmst_pkg::DENS_W-1:0]       density,
   output logic                              found
);
   import lmst_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   // Analysis box edges from a Q.8 centre, clipped to the frame.
   function automatic logic [2*CFG_W-1:0] box_edges(input logic [CEN_W-1:0] c8,
                                                    input logic [CFG_W-1:0] dim,
                                                    input logic [CFG_W-1:0] half);
      logic [CEN_W-1:0] hs;
      logic [CEN_W:0]   upper;
      logic [CFG_W-1:0] lo;
      logic [CFG_W-1:0] hi;
      hs    = {half, 8'b0};
      lo    = (c8 < hs) ? '0 : c8[CEN_W-1:8] - half;
      upper = {1'b0, c8} + {1'b0, hs};
      hi    = (upper > {1'b0, dim, 8'b0}) ? dim : c8[CEN_W-1:8] + half;
      return {lo, hi};
   endfunction

   logic [XW-1:0]           col_ff;
   logic [YW-1:0]           row_ff;
   logic [CEN_W-1:0]        cen_x_ff, cen_y_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [CFG_W-1:0]        box_ff [4];
   logic signed [ACC_W-1:0] acc_x_ff, acc_y_ff;
   logic [TOT_W-1:0]        tot_ff;
   logic [7:0]              peak_ff;
   logic [ROOT_W-1:0]       m_ff;
   logic [2*ROOT_W-1:0]     sq_ff;
   logic [2*ROOT_W+1:0]     nn_ff;
   logic [DIVS_W-1:0]       dv_ff;
   logic signed [SHIFT_W-1:0] sx_ff, sy_ff;
   logic [DENS_W-1:0]       dens_ff;
   logic signed [SHIFT_W-1:0] out_sx_ff, out_sy_ff;
   logic [DENS_W-1:0]       out_dens_ff;
   logic                    out_found_ff;

   logic [CFG_W-1:0]        w_eff, h_eff, dflt_eff, half;
   logic [2*CFG_W-1:0]      edges_x, edges_y;
   logic [CFG_W-1:0]        x_lo, x_hi, y_lo, y_hi;
   logic [DIM_W-1:0]        x13, y13;
   logic                    first, in_box, found_now;
   logic signed [21:0]      off_x, off_y;
   logic signed [30:0]      prod_x, prod_y;
   logic signed [ACC_W-1:0] acc_x_in, acc_y_in;
   logic [TOT_W-1:0]        tot_in, tot_base;
   logic [7:0]              peak_in, peak_base;
   logic [ROOT_W-1:0]       trial;
   logic [ROOT_W:0]         root_n;
   logic [DIVD_W-1:0]       mag_x, mag_y, dvd;
   logic [DIVS_W-1:0]       dvs;
   logic [DIVD_W-1:0]       quo;
   logic                    div_done;
   logic [CEN_W-1:0]        qsat;
   logic signed [SHIFT_W-1:0] sx_use, sy_use;
   logic signed [CEN_W+1:0] cx_sum, cy_sum;
   logic [CEN_W-1:0]        cx_new, cy_new, max_x, max_y;

   // Effective frame dimensions and default size.
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = 11'd1;
      end else if ({2'b0, cfg.frame_width} > DIM_W'(MAX_WIDTH)) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end else begin
         w_eff = cfg.frame_width;
      end
      if (cfg.frame_height == '0) begin
         h_eff = 11'd1;
      end else if ({2'b0, cfg.frame_height} > DIM_W'(MAX_HEIGHT)) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.frame_height;
      end
      dflt_eff = (cfg.default_size == '0) ? 11'd1 : cfg.default_size;
   end

   // Box for the pixel in hand: fresh edges on the first pixel of a frame.
   assign half    = CFG_W'((({3'b0, size_ff} * 15'd5) >> 3) >> 1);
   assign edges_x = box_edges(cen_x_ff, w_eff, half);
   assign edges_y = box_edges(cen_y_ff, h_eff, half);
   assign first   = (col_ff == '0) && (row_ff == '0);
   assign x_lo    = first ? edges_x[2*CFG_W-1:CFG_W] : box_ff[0];
   assign x_hi    = first ? edges_x[CFG_W-1:0]       : box_ff[1];
   assign y_lo    = first ? edges_y[2*CFG_W-1:CFG_W] : box_ff[2];
   assign y_hi    = first ? edges_y[CFG_W-1:0]       : box_ff[3];
   assign x13     = DIM_W'(col_ff);
   assign y13     = DIM_W'(row_ff);
   assign in_box  = !cfg.kernel_mode &&
                    (x13 >= {2'b0, x_lo}) && (x13 < {2'b0, x_hi}) &&
                    (y13 >= {2'b0, y_lo}) && (y13 < {2'b0, y_hi});

   // Weighted offsets from the centre and the running sums.
   assign off_x     = $signed({1'b0, x13, 8'b0}) - $signed({3'b0, cen_x_ff});
   assign off_y     = $signed({1'b0, y13, 8'b0}) - $signed({3'b0, cen_y_ff});
   assign prod_x    = 31'($signed({1'b0, luminance})) * 31'(off_x);
   assign prod_y    = 31'($signed({1'b0, luminance})) * 31'(off_y);
   assign tot_base  = first ? '0 : tot_ff;
   assign peak_base = first ? '0 : peak_ff;

   always_comb begin
      acc_x_in = first ? '0 : acc_x_ff;
      acc_y_in = first ? '0 : acc_y_ff;
      tot_in   = tot_base;
      peak_in  = peak_base;
      if (in_box) begin
         acc_x_in = acc_x_in + ACC_W'(prod_x);
         acc_y_in = acc_y_in + ACC_W'(prod_y);
         tot_in   = tot_base + {20'b0, luminance};
         if (luminance > peak_base) begin
            peak_in = luminance;
         end
      end
   end

   // Pixel position counters, box and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         tot_ff   <= '0;
         peak_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            box_ff[i] <= '0;
         end
      end else if (cmd.pix) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         tot_ff   <= tot_in;
         peak_ff  <= peak_in;
         if (first) begin
            box_ff[0] <= x_lo;
            box_ff[1] <= x_hi;
            box_ff[2] <= y_lo;
            box_ff[3] <= y_hi;
         end
         if (x13 + 13'd1 >= {2'b0, w_eff}) begin
            col_ff <= '0;
            if (y13 + 13'd1 >= {2'b0, h_eff}) begin
               row_ff <= '0;
            end else begin
               row_ff <= row_ff + YW'(1);
            end
         end else begin
            col_ff <= col_ff + XW'(1);
         end
      end
   end

   // Integer root, one bit per square then test step: largest m with m*m*peak < total.
   assign trial  = m_ff | (ROOT_W'(1) << cmd.bit_idx);
   assign root_n = {1'b0, m_ff} + 15'd1;

   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         m_ff <= '0;
      end
      if (cmd.sq_mul) begin
         sq_ff <= {{ROOT_W{1'b0}}, trial} * {{ROOT_W{1'b0}}, trial};
      end
      if (cmd.sq_test &&
          (({8'b0, sq_ff} * {{(2*ROOT_W){1'b0}}, peak_ff}) < {8'b0, tot_ff})) begin
         m_ff <= trial;
      end
      if (cmd.nsq) begin
         nn_ff <= {{(ROOT_W+1){1'b0}}, root_n} * {{(ROOT_W+1){1'b0}}, root_n};
      end
      if (cmd.n9) begin
         dv_ff <= DIVS_W'({nn_ff, 3'b0}) + DIVS_W'(nn_ff);
      end
   end

   // Divider operands: rounded shift components, then density.
   assign mag_x = acc_x_ff[ACC_W-1] ? DIVD_W'(-acc_x_ff) : DIVD_W'(acc_x_ff);
   assign mag_y = acc_y_ff[ACC_W-1] ? DIVD_W'(-acc_y_ff) : DIVD_W'(acc_y_ff);

   always_comb begin
      case (cmd.sel)
         SEL_X: begin
            dvd = mag_x + DIVD_W'(tot_ff >> 1);
            dvs = DIVS_W'(tot_ff);
         end
         SEL_Y: begin
            dvd = mag_y + DIVD_W'(tot_ff >> 1);
            dvs = DIVS_W'(tot_ff);
         end
         SEL_DEN: begin
            dvd = DIVD_W'({tot_ff, 10'b0});
            dvs = dv_ff;
         end
         default: begin
            dvd = '0;
            dvs = '0;
         end
      endcase
   end

   lmst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   assign qsat = (quo > DIVD_W'(SHIFT_MAX)) ? SHIFT_MAX : quo[CEN_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.sel)
            SEL_X: begin
               sx_ff <= acc_x_ff[ACC_W-1] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
            end
            SEL_Y: begin
               sy_ff <= acc_y_ff[ACC_W-1] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
            end
            SEL_DEN: begin
               dens_ff <= (quo > DIVD_W'(DENS_MAX)) ? DENS_MAX : quo[DENS_W-1:0];
            end
            default: begin
               dens_ff <= dens_ff;
            end
         endcase
      end
   end

   // New centre, saturated to the frame.
   assign found_now = (tot_ff != '0) && (peak_ff != '0);
   assign sx_use    = found_now ? sx_ff : '0;
   assign sy_use    = found_now ? sy_ff : '0;
   assign cx_sum    = $signed({2'b0, cen_x_ff}) + $signed({sx_use[SHIFT_W-1], sx_use});
   assign cy_sum    = $signed({2'b0, cen_y_ff}) + $signed({sy_use[SHIFT_W-1], sy_use});
   assign max_x     = {w_eff, 8'b0};
   assign max_y     = {h_eff, 8'b0};

   always_comb begin
      if (cx_sum[CEN_W+1]) begin
         cx_new = '0;
      end else if (cx_sum > $signed({2'b0, max_x})) begin
         cx_new = max_x;
      end else begin
         cx_new = cx_sum[CEN_W-1:0];
      end
      if (cy_sum[CEN_W+1]) begin
         cy_new = '0;
      end else if (cy_sum > $signed({2'b0, max_y})) begin
         cy_new = max_y;
      end else begin
         cy_new = cy_sum[CEN_W-1:0];
      end
   end

   // Window state, updated once per frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         cen_x_ff <= {FW_RESET, 7'b0};
         cen_y_ff <= {FH_RESET, 7'b0};
         size_ff  <= {DSIZE_RESET, 1'b0};
      end else if (cmd.fin) begin
         cen_x_ff <= cx_new;
         cen_y_ff <= cy_new;
         if (found_now) begin
            size_ff <= SIZE_W'({2'b0, root_n} + {1'b0, root_n, 1'b0});
         end else begin
            size_ff <= {dflt_eff, 1'b0};
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         out_sx_ff    <= sx_use;
         out_sy_ff    <= sy_use;
         out_dens_ff  <= found_now ? dens_ff : '0;
         out_found_ff <= found_now;
      end
   end

   assign sts.last     = (x13 + 13'd1 >= {2'b0, w_eff}) && (y13 + 13'd1 >= {2'b0, h_eff});
   assign sts.found    = found_now;
   assign sts.div_done = div_done;

   assign shift_x     = out_sx_ff;
   assign shift_y     = out_sy_ff;
   assign center_x    = cen_x_ff;
   assign center_y    = cen_y_ff;
   assign window_size = size_ff;
   assign density     = out_dens_ff;
   assign found       = out_found_ff;

endmodule
`default_nettype wire

// ----- rtl/core/lmst_ctrl.sv -----
`default_nettype none
module lmst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire lmst_pkg::sts_type sts,
   output lmst_pkg::cmd_type      cmd
);
   import lmst_pkg::*;

   typedef enum logic [9:0] {
      ST_RUN = 10'b0000000001,
      ST_CHK = 10'b0000000010,
      ST_SQA = 10'b0000000100,
      ST_SQB = 10'b0000001000,
      ST_NSQ = 10'b0000010000,
      ST_N9  = 10'b0000100000,
      ST_DST = 10'b0001000000,
      ST_DWT = 10'b0010000000,
      ST_FIN = 10'b0100000000,
      ST_OUT = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   div_sel_type      sel_ff, sel_in;

   // Next state and commands to the datapath.
   always_comb begin
      state_in      = state_ff;
      bit_in        = bit_ff;
      sel_in        = sel_ff;
      cmd           = '0;
      cmd.bit_idx   = bit_ff;
      cmd.sel       = sel_ff;
      case (state_ff)
         ST_RUN: begin
            cmd.pix = req_valid;
            if (req_valid && sts.last) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.sq_init = 1'b1;
            bit_in      = ROOT_TOP;
            state_in    = sts.found ? ST_SQA : ST_FIN;
         end
         ST_SQA: begin
            cmd.sq_mul = 1'b1;
            state_in   = ST_SQB;
         end
         ST_SQB: begin
            cmd.sq_test = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_NSQ;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_SQA;
            end
         end
         ST_NSQ: begin
            cmd.nsq  = 1'b1;
            state_in = ST_N9;
         end
         ST_N9: begin
            cmd.n9   = 1'b1;
            sel_in   = SEL_X;
            state_in = ST_DST;
         end
         ST_DST: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWT;
         end
         ST_DWT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               case (sel_ff)
                  SEL_X: begin
                     sel_in   = SEL_Y;
                     state_in = ST_DST;
                  end
                  SEL_Y: begin
                     sel_in   = SEL_DEN;
                     state_in = ST_DST;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         bit_ff   <= '0;
         sel_ff   <= SEL_X;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         sel_ff   <= sel_in;
      end
   end

   assign req_stall = (state_ff != ST_RUN);
   assign rsp_valid = (state_ff == ST_OUT);

endmodule
`default_nettype wire

// ----- rtl/core/luminance_mean_shift_tracker_unit.sv -----
`default_nettype none
// Channel   Direction  Handshake           Payload
// req       in         req_valid/stall     req_luminance
// rsp       out        rsp_valid/stall     shift, centre, size, density, found
// csr       in/out     psel/penable/pready frame_width .. default_size
//
// Pixels are taken one per cycle while a frame is in progress.
// After the last pixel of a frame the input stalls: with luminance in the box, a check,
// a 14-bit root one bit at a time, set-up of the divisor, three serial divisions
// (shift x, shift y, density) and an update; with nothing found, a check and an update.
// The result then waits in its register, input still stalled, until rsp_stall is low.
// Reset is synchronous and restores the register defaults and the window.
module luminance_mean_shift_tracker_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_luminance,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [lmst_pkg::SHIFT_W-1:0] rsp_shift_x,
   output logic signed [lmst_pkg::SHIFT_W-1:0] rsp_shift_y,
   output logic [lmst_pkg::CEN_W-1:0]         rsp_center_x,
   output logic [lmst_pkg::CEN_W-1:0]         rsp_center_y,
   output logic [lmst_pkg::SIZE_W-1:0]        rsp_window_size,
   output logic [lmst_pkg::DENS_W-1:0]        rsp_density,
   output logic                               rsp_found,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lmst_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [lmst_pkg::DATA_W-1:0]   pwdata,
   output logic [lmst_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import lmst_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic    wr_en;

   // Configuration registers.
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= FW_RESET;
         cfg_ff.frame_height <= FH_RESET;
         cfg_ff.kernel_mode  <= 1'b0;
         cfg_ff.default_size <= DSIZE_RESET;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_FRAME_WIDTH:  cfg_ff.frame_width  <= pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height <= pwdata[CFG_W-1:0];
            REG_KERNEL_MODE:  cfg_ff.kernel_mode  <= pwdata[0];
            REG_DEFAULT_SIZE: cfg_ff.default_size <= pwdata[CFG_W-1:0];
            default:          cfg_ff.kernel_mode  <= cfg_ff.kernel_mode;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_ff.frame_height);
         REG_KERNEL_MODE:  prdata = DATA_W'(cfg_ff.kernel_mode);
         REG_DEFAULT_SIZE: prdata = DATA_W'(cfg_ff.default_size);
         default:          prdata = '0;
      endcase
   end

   lmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lmst_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .sts         (sts),
      .luminance   (req_luminance),
      .shift_x     (rsp_shift_x),
      .shift_y     (rsp_shift_y),
      .center_x    (rsp_center_x),
      .center_y    (rsp_center_y),
      .window_size (rsp_window_size),
      .density     (rsp_density),
      .found       (rsp_found)
   );

endmodule
`default_nettype wire

// ----- tb/tb_luminance_mean_shift_tracker_unit.sv -----
`default_nettype none
module tb_luminance_mean_shift_tracker_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import lmst_pkg::*;

   localparam int LIMIT_W = 1024;
   localparam int LIMIT_H = 1024;

   // One tracking result as seen on the rsp channel.
   typedef struct {
      logic signed [SHIFT_W-1:0] shift_x;
      logic signed [SHIFT_W-1:0] shift_y;
      logic [CEN_W-1:0]          center_x;
      logic [CEN_W-1:0]          center_y;
      logic [SIZE_W-1:0]         window_size;
      logic [DENS_W-1:0]         density;
      logic                      found;
   } track_result_type;

   // Tracker predictor: follows the pixel stream and queues the frame-end results.
   class track_scoreboard;
      bit [CFG_W-1:0] frame_w, frame_h, dflt_size;
      bit             kernel_gauss;
      longint         cen_col, cen_row, win_size;
      longint         bound[4];
      longint         col, row;
      longint         sum_x, sum_y, lum_total, lum_peak;
      track_result_type pending_q[$];
      int             mismatches;

      function new();
         frame_w      = FW_RESET;
         frame_h      = FH_RESET;
         dflt_size    = DSIZE_RESET;
         kernel_gauss = 0;
         cen_col      = longint'(FW_RESET) * 128;
         cen_row      = longint'(FH_RESET) * 128;
         win_size     = 2 * longint'(DSIZE_RESET);
         foreach (bound[i]) bound[i] = 0;
         col = 0;
         row = 0;
         clear_sums();
         mismatches = 0;
      endfunction

      function void clear_sums();
         sum_x = 0;
         sum_y = 0;
         lum_total = 0;
         lum_peak = 0;
      endfunction

      function longint eff_dim(bit [CFG_W-1:0] v, int mx);
         if (v == 0) return 1;
         return (v > mx) ? mx : v;
      endfunction

      function int frame_pixels();
         return eff_dim(frame_w, LIMIT_W) * eff_dim(frame_h, LIMIT_H);
      endfunction

      function void write_reg(logic [1:0] idx, bit [CFG_W-1:0] val);
         case (idx)
            REG_FRAME_WIDTH:  frame_w = val;
            REG_FRAME_HEIGHT: frame_h = val;
            REG_KERNEL_MODE:  kernel_gauss = val[0];
            REG_DEFAULT_SIZE: dflt_size = val;
            default: ;
         endcase
      endfunction

      // Box bounds around one centre coordinate, clipped to the frame.
      function void box_edges(longint c8, longint dim, longint half,
                              output longint lo, output longint hi);
         longint l, h;
         l  = c8 - half * 256;
         h  = c8 + half * 256;
         lo = (l < 0) ? 0 : (l >>> 8);
         hi = (h > dim * 256) ? dim : (h >>> 8);
      endfunction

      // Rounded division, ties away from zero, saturated magnitude.
      function longint round_div(longint num, longint den);
         longint mag, q;
         mag = (num < 0) ? -num : num;
         q   = (mag + den / 2) / den;
         if (q > 262144) q = 262144;
         return (num < 0) ? -q : q;
      endfunction

      function longint clamp_centre(longint v, longint dim);
         if (v < 0) return 0;
         return (v > dim * 256) ? dim * 256 : v;
      endfunction

      // An accepted pixel transaction.
      function void note_pixel(bit [7:0] lum);
         longint w, h, half, sx, sy, dens, lo, hi, mid;
         track_result_type r;
         w = eff_dim(frame_w, LIMIT_W);
         h = eff_dim(frame_h, LIMIT_H);
         if (col == 0 && row == 0) begin
            half = ((5 * win_size) >> 3) >> 1;
            box_edges(cen_col, w, half, bound[0], bound[1]);
            box_edges(cen_row, h, half, bound[2], bound[3]);
            clear_sums();
         end
         if (!kernel_gauss && col >= bound[0] && col < bound[1] &&
             row >= bound[2] && row < bound[3]) begin
            sum_x += longint'(lum) * (col * 256 - cen_col);
            sum_y += longint'(lum) * (row * 256 - cen_row);
            lum_total = (lum_total + lum) & 64'hFFF_FFFF;
            if (lum > lum_peak) lum_peak = lum;
         end
         if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
               row  = 0;
               sx   = 0;
               sy   = 0;
               dens = 0;
               r.found = 0;
               if (lum_total > 0 && lum_peak > 0) begin
                  r.found = 1;
                  sx = round_div(sum_x, lum_total);
                  sy = round_div(sum_y, lum_total);
                  lo = 1;
                  hi = 16384;
                  while (lo < hi) begin
                     mid = (lo + hi) / 2;
                     if (mid * mid * lum_peak >= lum_total) hi = mid;
                     else lo = mid + 1;
                  end
                  win_size = (3 * lo) & 12'hFFF;
                  dens = (lum_total * 1024) / (9 * lo * lo);
                  if (dens > 65535) dens = 65535;
               end else begin
                  win_size = 2 * ((dflt_size == 0) ? 1 : longint'(dflt_size));
               end
               cen_col = clamp_centre(cen_col + sx, w);
               cen_row = clamp_centre(cen_row + sy, h);
               r.shift_x     = sx[SHIFT_W-1:0];
               r.shift_y     = sy[SHIFT_W-1:0];
               r.center_x    = cen_col[CEN_W-1:0];
               r.center_y    = cen_row[CEN_W-1:0];
               r.window_size = win_size[SIZE_W-1:0];
               r.density     = dens[DENS_W-1:0];
               pending_q = {pending_q, r};
               clear_sums();
            end else begin
               row = row + 1;
            end
         end else begin
            col = col + 1;
         end
      endfunction

      // An accepted result transaction against the oldest prediction.
      function void check_result(track_result_type got);
         track_result_type exp_r;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: shift %0d,%0d centre %0d,%0d",
                        got.shift_x, got.shift_y, got.center_x, got.center_y);
            return;
         end
         exp_r = pending_q.pop_front();
         if (got.shift_x !== exp_r.shift_x || got.shift_y !== exp_r.shift_y ||
             got.center_x !== exp_r.center_x || got.center_y !== exp_r.center_y ||
             got.window_size !== exp_r.window_size || got.density !== exp_r.density ||
             got.found !== exp_r.found) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch: expected shift %0d,%0d centre %0d,%0d %s",
                        exp_r.shift_x, exp_r.shift_y, exp_r.center_x, exp_r.center_y,
                        $sformatf("size %0d dens %0d found %0d", exp_r.window_size,
                                  exp_r.density, exp_r.found));
               $display("   got shift %0d,%0d centre %0d,%0d size %0d dens %0d found %0d",
                        got.shift_x, got.shift_y, got.center_x, got.center_y,
                        got.window_size, got.density, got.found);
            end
         end
      endfunction
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_stall;
   logic [7:0]                req_luminance = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 0;
   logic signed [SHIFT_W-1:0] rsp_shift_x, rsp_shift_y;
   logic [CEN_W-1:0]          rsp_center_x, rsp_center_y;
   logic [SIZE_W-1:0]         rsp_window_size;
   logic [DENS_W-1:0]         rsp_density;
   logic                      rsp_found;
   logic                      psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0]         paddr = '0;
   logic [DATA_W-1:0]         pwdata = '0;
   logic [DATA_W-1:0]         prdata;
   logic                      pready;

   track_scoreboard sb;
   int  hold_request = 0;
   bit  gaps_off = 0;
   int  pixel_count = 0;

   luminance_mean_shift_tracker_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_luminance(req_luminance),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_shift_x(rsp_shift_x), .rsp_shift_y(rsp_shift_y),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_window_size(rsp_window_size), .rsp_density(rsp_density),
      .rsp_found(rsp_found),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("luminance_mean_shift_tracker_unit regression: fail");
      $finish;
   end

   // Receiver: checks accepted results and stalls in runs, with one long hold-off on request.
   initial begin : receiver
      int               hold_left, run_left;
      bit               run_stall;
      track_result_type got;
      hold_left = 0;
      run_left  = 0;
      run_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.shift_x     = rsp_shift_x;
            got.shift_y     = rsp_shift_y;
            got.center_x    = rsp_center_x;
            got.center_y    = rsp_center_y;
            got.window_size = rsp_window_size;
            got.density     = rsp_density;
            got.found       = rsp_found;
            sb.check_result(got);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: begin run_stall = 0; run_left = $urandom_range(1, 30); end
                  9:             begin run_stall = 1; run_left = $urandom_range(20, 80); end
                  default:       begin run_stall = 1; run_left = $urandom_range(1, 3); end
               endcase
            end
            run_left--;
            rsp_stall <= run_stall;
         end
      end
   end

   // One register write: setup cycle, then access cycle.
   task automatic csr_write(logic [1:0] idx, bit [CFG_W-1:0] val);
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= {idx, 2'b00};
      pwdata  <= DATA_W'(val);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      sb.write_reg(idx, val);
   endtask

   // Block idle: every result back, then the frame-end latency.
   task automatic wait_drained();
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic configure(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h, bit km,
                            bit [CFG_W-1:0] ds);
      wait_drained();
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_KERNEL_MODE, km);
      csr_write(REG_DEFAULT_SIZE, ds);
   endtask

   // One pixel transaction, followed by a random gap.
   task automatic send_pixel(bit [7:0] lum);
      int gap;
      req_valid     <= 1;
      req_luminance <= lum;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(lum);
      pixel_count++;
      gap = 0;
      if (!gaps_off) begin
         case ($urandom_range(0, 19))
            0:                   gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5, 6, 7: gap = $urandom_range(1, 3);
            default:             gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Whole frames in one style: 0 random, 1 dark, 2 saturated, 3 sparse, 4 one bright pixel.
   task automatic send_frames(int count, int style);
      int n, spot;
      bit [7:0] lum;
      for (int f = 0; f < count; f++) begin
         n    = sb.frame_pixels();
         spot = $urandom_range(0, n - 1);
         for (int i = 0; i < n; i++) begin
            case (style)
               1: lum = 8'd0;
               2: lum = 8'd255;
               3: lum = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
               4: lum = (i == spot) ? 8'($urandom_range(1, 255)) : 8'd0;
               default: lum = 8'($urandom);
            endcase
            send_pixel(lum);
         end
      end
      req_valid <= 0;
   endtask

   initial begin : stimulus
      bit [CFG_W-1:0] w, h, ds;
      bit km;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: small frames through each special case.
      configure(4, 3, 0, 1);
      send_frames(1, 2);
      send_frames(1, 1);
      send_frames(1, 4);
      configure(0, 0, 0, 0);
      send_frames(2, 0);
      send_frames(1, 1);
      configure(3, 2, 1, 2047);
      send_frames(1, 2);
      configure(2, 2, 0, 1024);
      send_frames(2, 1);
      send_frames(2, 2);

      // Largest frame width in one row, then a single column.
      configure(2047, 0, 0, 7);
      send_frames(1, 3);
      configure(1, 100, 0, 300);
      send_frames(1, 0);

      // Long receiver hold-off while frames keep coming.
      configure(4, 4, 0, 5);
      hold_request = 1500;
      send_frames(8, 0);

      // Random phases, mostly small frames.
      while (pixel_count < 1500) begin
         w  = 11'($urandom_range(1, 8));
         h  = 11'($urandom_range(1, 8));
         ds = 11'($urandom_range(1, 20));
         km = ($urandom_range(0, 9) == 0);
         case ($urandom_range(0, 11))
            0: w = 11'($urandom_range(17, 100));
            1: h = 11'($urandom_range(0, 1));
            2: ds = ($urandom_range(0, 1)) ? 11'd0 : 11'($urandom_range(1024, 2047));
            default: ;
         endcase
         if (w > 16) h = 11'($urandom_range(0, 1));
         configure(w, h, km, ds);
         gaps_off = ($urandom_range(0, 3) == 0);
         send_frames($urandom_range(1, 6), $urandom_range(0, 4));
      end
      gaps_off = 0;

      wait_drained();
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("luminance_mean_shift_tracker_unit regression: pass");
      else
         $display("luminance_mean_shift_tracker_unit regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
